// ===== sv/att_pkg.sv =====
// Shared constants, formats and the arctangent table of the tilt angle block.
`default_nettype none

package att_pkg;

  // Default and limit of the rotation count
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned TABLE_LEN        = 24;

  // Fixed formats that follow from the 16-bit sample fields
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned NUM_W    = SAMPLE_W + 1;  // negated sample
  localparam int unsigned SQ_W     = 2 * SAMPLE_W - 1;
  localparam int unsigned SUM_W    = 2 * SAMPLE_W;
  localparam int unsigned FRAC_W   = 8;             // fraction bits of magnitude
  localparam int unsigned ROOT_W   = (SUM_W + 2 * FRAC_W) / 2;
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned REM_W    = ROOT_W + 3;
  localparam int unsigned VEC_W    = ROOT_W + 3;    // CORDIC x/y, signed
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned ANGLE_W  = 15;
  localparam int unsigned ACC_FRAC = 16;

  localparam logic signed [ANGLE_W-1:0] ABSENT_MARK = -15'sd9900;
  localparam logic signed [ANGLE_W-1:0] RIGHT_ANGLE = 15'sd9000;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  // round(atan(2^-i) in degrees * 100 * 2^16)
  function automatic logic signed [ACC_W-1:0] atan_entry(input int unsigned idx);
    logic signed [ACC_W-1:0] val;
    case (idx)
      0:       val = 32'sd294912000;
      1:       val = 32'sd174096719;
      2:       val = 32'sd91987925;
      3:       val = 32'sd46694507;
      4:       val = 32'sd23437865;
      5:       val = 32'sd11730358;
      6:       val = 32'sd5866610;
      7:       val = 32'sd2933484;
      8:       val = 32'sd1466764;
      9:       val = 32'sd733385;
      10:      val = 32'sd366693;
      11:      val = 32'sd183346;
      12:      val = 32'sd91673;
      13:      val = 32'sd45837;
      14:      val = 32'sd22918;
      15:      val = 32'sd11459;
      16:      val = 32'sd5730;
      17:      val = 32'sd2865;
      18:      val = 32'sd1432;
      19:      val = 32'sd716;
      20:      val = 32'sd358;
      21:      val = 32'sd179;
      22:      val = 32'sd90;
      23:      val = 32'sd45;
      default: val = '0;
    endcase
    return val;
  endfunction

  function automatic int unsigned used_steps(input int unsigned steps);
    return (steps > TABLE_LEN) ? TABLE_LEN : steps;
  endfunction

  // square, sum, root digits, rotations, rounding
  function automatic int unsigned lane_latency(input int unsigned steps);
    return 2 + SQRT_STEPS + used_steps(steps) + 1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/accel_tilt_angles.sv =====
// Top level of the accelerometer tilt angle block: roll and pitch lanes.
//
// Usage: raise start_i with a sample on accel_x_i, accel_y_i and accel_z_i;
// the request is taken at a rising edge with start_i high and busy_o low.
// busy_o never rises, so a new sample may follow in every cycle.
// Each request yields one result: done_o is high for one cycle with
// roll_angle_o and pitch_angle_o in hundredths of a degree (-9000..9000).
// Pipeline order: squares, sum, one square root digit a stage, one CORDIC
// rotation a stage, then rounding.
// Throughput is one sample a clock; the depth of the root and rotation
// pipelines sets the latency.
// cfg_we_i/cfg_data_i write sensor_present; with it clear both angles
// read -9900. Write it only while no result is outstanding.
// Reset clears sensor_present and all in-flight requests.
// The receiver cannot stall: a result is shown for exactly one cycle.
`default_nettype none

module accel_tilt_angles #(
  parameter int unsigned CORDIC_STEPS = att_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output      logic                                busy_o,
  input  wire logic signed [att_pkg::SAMPLE_W-1:0] accel_x_i,
  input  wire logic signed [att_pkg::SAMPLE_W-1:0] accel_y_i,
  input  wire logic signed [att_pkg::SAMPLE_W-1:0] accel_z_i,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_data_i,
  output      logic                                done_o,
  output      att_pkg::angle_t                     roll_angle_o,
  output      att_pkg::angle_t                     pitch_angle_o
);

  localparam int unsigned LAT   = att_pkg::lane_latency(CORDIC_STEPS);
  localparam int unsigned NUM_W = att_pkg::NUM_W;

  logic                    present_q;
  logic [LAT-1:0]          vld_q, pres_q;
  logic                    accept;
  logic signed [NUM_W-1:0] roll_num, pitch_num;
  att_pkg::angle_t         roll_raw, pitch_raw;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign roll_num  = NUM_W'(accel_y_i);
  assign pitch_num = -NUM_W'(accel_x_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      vld_q     <= '0;
      pres_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        present_q <= cfg_data_i;
      end
      // advance the request flags with the lane data
      vld_q  <= {vld_q[LAT-2:0], accept};
      pres_q <= {pres_q[LAT-2:0], present_q};
    end
  end

  att_tilt_lane #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_roll (
    .clk_i   (clk_i),
    .num_i   (roll_num),
    .a_i     (accel_x_i),
    .b_i     (accel_z_i),
    .angle_o (roll_raw)
  );

  att_tilt_lane #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_pitch (
    .clk_i   (clk_i),
    .num_i   (pitch_num),
    .a_i     (accel_y_i),
    .b_i     (accel_z_i),
    .angle_o (pitch_raw)
  );

  assign done_o        = vld_q[LAT-1];
  assign roll_angle_o  = pres_q[LAT-1] ? roll_raw  : att_pkg::ABSENT_MARK;
  assign pitch_angle_o = pres_q[LAT-1] ? pitch_raw : att_pkg::ABSENT_MARK;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("result strobe missing after pipeline latency");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (roll_angle_o == att_pkg::ABSENT_MARK ||
                (roll_angle_o >= -att_pkg::RIGHT_ANGLE &&
                 roll_angle_o <= att_pkg::RIGHT_ANGLE)))
    else $error("roll angle out of range");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pitch_angle_o == att_pkg::ABSENT_MARK ||
                (pitch_angle_o >= -att_pkg::RIGHT_ANGLE &&
                 pitch_angle_o <= att_pkg::RIGHT_ANGLE)))
    else $error("pitch angle out of range");

  a_absent_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !pres_q[LAT-1]) |->
      (roll_angle_o == att_pkg::ABSENT_MARK && pitch_angle_o == att_pkg::ABSENT_MARK))
    else $error("absent marker not on both angles");

endmodule

`default_nettype wire

// ===== sv/att_tilt_lane.sv =====
// One tilt angle lane: squares, pipelined square root and CORDIC vectoring.
`default_nettype none

module att_tilt_lane #(
  parameter int unsigned CORDIC_STEPS = att_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic signed [att_pkg::NUM_W-1:0]       num_i,
  input  wire logic signed [att_pkg::SAMPLE_W-1:0]    a_i,
  input  wire logic signed [att_pkg::SAMPLE_W-1:0]    b_i,
  output      att_pkg::angle_t                        angle_o
);

  localparam int unsigned NSTEP  = att_pkg::used_steps(CORDIC_STEPS);
  localparam int unsigned NUM_W  = att_pkg::NUM_W;
  localparam int unsigned SQ_W   = att_pkg::SQ_W;
  localparam int unsigned SUM_W  = att_pkg::SUM_W;
  localparam int unsigned ROOT_W = att_pkg::ROOT_W;
  localparam int unsigned REM_W  = att_pkg::REM_W;
  localparam int unsigned VEC_W  = att_pkg::VEC_W;
  localparam int unsigned ACC_W  = att_pkg::ACC_W;
  localparam int unsigned NSQ    = att_pkg::SQRT_STEPS;
  localparam int unsigned SUM_PAIRS = SUM_W / 2;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (att_pkg::ACC_FRAC - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(att_pkg::RIGHT_ANGLE);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;

  // Stage 1: squares
  logic signed [2*att_pkg::SAMPLE_W-1:0] a_sq, b_sq;
  logic [SQ_W-1:0]          a_sq_q, b_sq_q;
  logic signed [NUM_W-1:0]  num1_q;

  assign a_sq = a_i * a_i;
  assign b_sq = b_i * b_i;

  always_ff @(posedge clk_i) begin
    a_sq_q <= a_sq[SQ_W-1:0];
    b_sq_q <= b_sq[SQ_W-1:0];
    num1_q <= num_i;
  end

  // Stage 2: sum of squares
  logic [SUM_W-1:0]         sum_q;
  logic signed [NUM_W-1:0]  num2_q;

  always_ff @(posedge clk_i) begin
    sum_q  <= SUM_W'(a_sq_q) + SUM_W'(b_sq_q);
    num2_q <= num1_q;
  end

  // Root of sum * 2^16, one result bit a stage
  logic [REM_W-1:0]         rem_q  [NSQ];
  logic [ROOT_W-1:0]        root_q [NSQ];
  logic [SUM_W-1:0]         rsum_q [NSQ];
  logic signed [NUM_W-1:0]  rnum_q [NSQ];

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    logic [REM_W-1:0]        rem_in, shifted, trial;
    logic [ROOT_W-1:0]       root_in;
    logic [SUM_W-1:0]        sum_in;
    logic signed [NUM_W-1:0] num_in;
    logic [1:0]              pair;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign sum_in  = sum_q;
      assign num_in  = num2_q;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign sum_in  = rsum_q[j-1];
      assign num_in  = rnum_q[j-1];
    end

    // fraction bits below the sum are zero
    if (j < SUM_PAIRS) begin : g_pair
      assign pair = sum_in[SUM_W-1-2*j -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign shifted = {rem_in[REM_W-3:0], pair};
    assign trial   = REM_W'({root_in, 2'b01});

    always_ff @(posedge clk_i) begin
      if (shifted >= trial) begin
        rem_q[j]  <= shifted - trial;
        root_q[j] <= {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q[j]  <= shifted;
        root_q[j] <= {root_in[ROOT_W-2:0], 1'b0};
      end
      rsum_q[j] <= sum_in;
      rnum_q[j] <= num_in;
    end
  end

  // CORDIC vectoring, one rotation a stage
  logic signed [VEC_W-1:0]  m_q    [NSTEP];
  logic signed [VEC_W-1:0]  n_q    [NSTEP];
  logic signed [ACC_W-1:0]  acc_q  [NSTEP];
  logic                     nzero_q [NSTEP];
  logic                     nneg_q  [NSTEP];
  logic                     mzero_q [NSTEP];

  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    localparam logic signed [ACC_W-1:0] TAB = att_pkg::atan_entry(i);
    logic signed [VEC_W-1:0] m_in, n_in, m_sh, n_sh;
    logic signed [ACC_W-1:0] acc_in;
    logic                    nzero_in, nneg_in, mzero_in;

    if (i == 0) begin : g_first
      assign m_in     = VEC_W'(root_q[NSQ-1]);
      assign n_in     = VEC_W'(rnum_q[NSQ-1]) <<< att_pkg::FRAC_W;
      assign acc_in   = '0;
      assign nzero_in = (rnum_q[NSQ-1] == '0);
      assign nneg_in  = rnum_q[NSQ-1][NUM_W-1];
      assign mzero_in = (root_q[NSQ-1] == '0);
    end else begin : g_next
      assign m_in     = m_q[i-1];
      assign n_in     = n_q[i-1];
      assign acc_in   = acc_q[i-1];
      assign nzero_in = nzero_q[i-1];
      assign nneg_in  = nneg_q[i-1];
      assign mzero_in = mzero_q[i-1];
    end

    assign m_sh = m_in >>> i;
    assign n_sh = n_in >>> i;

    always_ff @(posedge clk_i) begin
      if (n_in > 0) begin
        m_q[i]   <= m_in + n_sh;
        n_q[i]   <= n_in - m_sh;
        acc_q[i] <= acc_in + TAB;
      end else begin
        m_q[i]   <= m_in - n_sh;
        n_q[i]   <= n_in + m_sh;
        acc_q[i] <= acc_in - TAB;
      end
      nzero_q[i] <= nzero_in;
      nneg_q[i]  <= nneg_in;
      mzero_q[i] <= mzero_in;
    end
  end

  // Round half up, saturate, apply the degenerate cases
  logic signed [ACC_W-1:0] rounded;
  att_pkg::angle_t         angle_d, angle_q;

  assign rounded = (acc_q[NSTEP-1] + HALF) >>> att_pkg::ACC_FRAC;

  always_comb begin
    if (nzero_q[NSTEP-1]) begin
      angle_d = '0;
    end else if (mzero_q[NSTEP-1]) begin
      angle_d = nneg_q[NSTEP-1] ? -att_pkg::RIGHT_ANGLE : att_pkg::RIGHT_ANGLE;
    end else if (rounded > SAT_HI) begin
      angle_d = att_pkg::RIGHT_ANGLE;
    end else if (rounded < SAT_LO) begin
      angle_d = -att_pkg::RIGHT_ANGLE;
    end else begin
      angle_d = rounded[att_pkg::ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
  end

  assign angle_o = angle_q;

endmodule

`default_nettype wire
